### hdl/hsl2rgb_pkg.sv
// hsl2rgb_pkg: beat types, codes and fixed-point constants of the hsl/hsv to rgb converter
// used by hsl_hsv_to_rgb_unit and hsl2rgb_checker; depends on nothing
`default_nettype none

package hsl2rgb_pkg;

  // colour model codes
  localparam logic OP_HSL = 1'b0;
  localparam logic OP_HSV = 1'b1;

  // geometry of the hue circle
  localparam int HUE_W      = 9;
  localparam int CH_W       = 8;
  localparam int FULL_TURN  = 360;
  localparam int SECTOR_DEG = 60;
  localparam int CH_MAX     = 255;

  // every quantity is scaled by 255*255*60; a channel is num / (255*60)
  localparam int SCALE_DIV  = CH_MAX * SECTOR_DEG;
  localparam int PROD_W     = 2 * CH_W;        // amp * sat
  localparam int T_W        = 6;               // 0..60
  localparam int PART_W     = 22;              // cn, xn, mn, level*15300
  localparam int NUM_W      = PART_W + 1;      // part + mn

  // floor(num / 15300) == (num * RECIP) >> RECIP_SHIFT for every num below 2**23
  localparam int RECIP_SHIFT = 37;
  localparam int RECIP_W     = 24;
  localparam logic [RECIP_W-1:0] RECIP = 24'd8982939;
  localparam int QUOT_W      = 10;

  // hue sectors, named after the band they start at
  typedef enum logic [2:0] {
    SEC_RED     = 3'd0,
    SEC_YELLOW  = 3'd1,
    SEC_GREEN   = 3'd2,
    SEC_CYAN    = 3'd3,
    SEC_BLUE    = 3'd4,
    SEC_MAGENTA = 3'd5
  } sector_t;

  typedef struct packed {
    logic            op;
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  level;
  } pix_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

### hdl/hsl_hsv_to_rgb_unit.sv
// hsl_hsv_to_rgb_unit: six-stage pipelined hsl/hsv to 8-bit rgb converter
// depends on hsl2rgb_pkg for beat types, sector codes and scale constants
`default_nettype none

// channel   direction  beat type             handshake
// pix       in         hsl2rgb_pkg::pix_t    pix_valid / pix_ready
// rgb       out        hsl2rgb_pkg::rgb_t    rgb_valid / rgb_ready
//
// one beat per cycle while rgb_ready holds; a beat taken in passes s1..s5, then rgb
// the depth is set by the chain of products: amp*sat, then *60 / *t, then the
// reciprocal multiply that stands in for the divide by 15300, each behind a register
// rst clears only the valid bits of the six stages; payload registers are not reset
// each stage moves when it is empty or the stage after it moves, so bubbles close up
// under backpressure and a stalled beat sits still in its stage, never lost or repeated

module hsl_hsv_to_rgb_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pix_valid,
  output logic                   pix_ready,
  input  wire hsl2rgb_pkg::pix_t pix,
  output logic                   rgb_valid,
  input  wire logic              rgb_ready,
  output hsl2rgb_pkg::rgb_t      rgb
);

  localparam int NSTAGE = 6;

  // stage 1: hue folded into sector and triangle height, amplitude chosen per model
  typedef struct packed {
    logic                               op;
    hsl2rgb_pkg::sector_t               sector;
    logic [hsl2rgb_pkg::T_W-1:0]        t;
    logic [hsl2rgb_pkg::CH_W-1:0]       amp;
    logic [hsl2rgb_pkg::CH_W-1:0]       sat;
    logic [hsl2rgb_pkg::CH_W-1:0]       lvl;
  } s1_t;

  // stage 2: amp * sat and level * 15300
  typedef struct packed {
    logic                               op;
    hsl2rgb_pkg::sector_t               sector;
    logic [hsl2rgb_pkg::T_W-1:0]        t;
    logic [hsl2rgb_pkg::PROD_W-1:0]     prod;
    logic [hsl2rgb_pkg::PART_W-1:0]     lm;
  } s2_t;

  // stage 3: chroma, secondary and offset on the common scale
  typedef struct packed {
    hsl2rgb_pkg::sector_t               sector;
    logic [hsl2rgb_pkg::PART_W-1:0]     cn;
    logic [hsl2rgb_pkg::PART_W-1:0]     xn;
    logic [hsl2rgb_pkg::PART_W-1:0]     mn;
  } s3_t;

  // stage 4: routed numerators
  typedef struct packed {
    logic [hsl2rgb_pkg::NUM_W-1:0]      nr;
    logic [hsl2rgb_pkg::NUM_W-1:0]      ng;
    logic [hsl2rgb_pkg::NUM_W-1:0]      nb;
  } s4_t;

  // stage 5: quotients before the clamp
  typedef struct packed {
    logic [hsl2rgb_pkg::QUOT_W-1:0]     qr;
    logic [hsl2rgb_pkg::QUOT_W-1:0]     qg;
    logic [hsl2rgb_pkg::QUOT_W-1:0]     qb;
  } s5_t;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  s5_t s5, s5_next;
  hsl2rgb_pkg::rgb_t rgb_next;

  // ---------------------------------------------------------------- flow control
  // a stage takes a new beat when it is empty or its own beat moves on
  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || rgb_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign pix_ready = en[0];
  assign rgb_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pix_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic [hsl2rgb_pkg::HUE_W-1:0] hue_w;
  logic [hsl2rgb_pkg::HUE_W-1:0] hm_w;
  logic [6:0]                    hm;
  logic [hsl2rgb_pkg::HUE_W-1:0] twice;
  logic [hsl2rgb_pkg::CH_W-1:0]  spread;

  always_comb begin
    // hue of 360 and up wraps once
    if (pix.hue >= hsl2rgb_pkg::HUE_W'(hsl2rgb_pkg::FULL_TURN)) begin
      hue_w = pix.hue - hsl2rgb_pkg::HUE_W'(hsl2rgb_pkg::FULL_TURN);
    end else begin
      hue_w = pix.hue;
    end

    // sector and position within a 120-degree period
    if (hue_w >= 9'd300) begin
      s1_next.sector = hsl2rgb_pkg::SEC_MAGENTA;
    end else if (hue_w >= 9'd240) begin
      s1_next.sector = hsl2rgb_pkg::SEC_BLUE;
    end else if (hue_w >= 9'd180) begin
      s1_next.sector = hsl2rgb_pkg::SEC_CYAN;
    end else if (hue_w >= 9'd120) begin
      s1_next.sector = hsl2rgb_pkg::SEC_GREEN;
    end else if (hue_w >= 9'd60) begin
      s1_next.sector = hsl2rgb_pkg::SEC_YELLOW;
    end else begin
      s1_next.sector = hsl2rgb_pkg::SEC_RED;
    end

    if (hue_w >= 9'd240) begin
      hm_w = hue_w - 9'd240;
    end else if (hue_w >= 9'd120) begin
      hm_w = hue_w - 9'd120;
    end else begin
      hm_w = hue_w;
    end
    hm = hm_w[6:0];

    // triangle 60 - |hm - 60|
    if (hm >= 7'(hsl2rgb_pkg::SECTOR_DEG)) begin
      s1_next.t = hsl2rgb_pkg::T_W'(7'(2 * hsl2rgb_pkg::SECTOR_DEG) - hm);
    end else begin
      s1_next.t = hsl2rgb_pkg::T_W'(hm);
    end

    // hsl amplitude 255 - |2l - 255|, hsv amplitude is the value itself
    twice = {pix.level, 1'b0};
    if (twice >= 9'(hsl2rgb_pkg::CH_MAX)) begin
      spread = 8'(twice - 9'(hsl2rgb_pkg::CH_MAX));
    end else begin
      spread = 8'(9'(hsl2rgb_pkg::CH_MAX) - twice);
    end
    if (pix.op == hsl2rgb_pkg::OP_HSV) begin
      s1_next.amp = pix.level;
    end else begin
      s1_next.amp = 8'(hsl2rgb_pkg::CH_MAX) - spread;
    end

    s1_next.op  = pix.op;
    s1_next.sat = pix.saturation;
    s1_next.lvl = pix.level;
  end

  // ---------------------------------------------------------------- stage 2
  always_comb begin
    s2_next.op     = s1.op;
    s2_next.sector = s1.sector;
    s2_next.t      = s1.t;
    s2_next.prod   = hsl2rgb_pkg::PROD_W'(s1.amp) * hsl2rgb_pkg::PROD_W'(s1.sat);
    s2_next.lm     = hsl2rgb_pkg::PART_W'(s1.lvl) *
                     hsl2rgb_pkg::PART_W'(hsl2rgb_pkg::SCALE_DIV);
  end

  // ---------------------------------------------------------------- stage 3
  logic [hsl2rgb_pkg::PART_W-1:0] half;

  always_comb begin
    s3_next.sector = s2.sector;
    s3_next.cn = hsl2rgb_pkg::PART_W'(s2.prod) *
                 hsl2rgb_pkg::PART_W'(hsl2rgb_pkg::SECTOR_DEG);
    s3_next.xn = hsl2rgb_pkg::PART_W'(s2.prod) * hsl2rgb_pkg::PART_W'(s2.t);
    half       = hsl2rgb_pkg::PART_W'(s2.prod) *
                 hsl2rgb_pkg::PART_W'(hsl2rgb_pkg::SECTOR_DEG / 2);
    // offset never goes below zero: amp*sat*60 <= level*15300 in hsv,
    // amp*sat*30 <= level*15300 in hsl
    if (s2.op == hsl2rgb_pkg::OP_HSV) begin
      s3_next.mn = s2.lm - s3_next.cn;
    end else begin
      s3_next.mn = s2.lm - half;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic [hsl2rgb_pkg::PART_W-1:0] pr, pg, pb;

  always_comb begin
    case (s3.sector)
      hsl2rgb_pkg::SEC_RED: begin
        pr = s3.cn; pg = s3.xn; pb = '0;
      end
      hsl2rgb_pkg::SEC_YELLOW: begin
        pr = s3.xn; pg = s3.cn; pb = '0;
      end
      hsl2rgb_pkg::SEC_GREEN: begin
        pr = '0;    pg = s3.cn; pb = s3.xn;
      end
      hsl2rgb_pkg::SEC_CYAN: begin
        pr = '0;    pg = s3.xn; pb = s3.cn;
      end
      hsl2rgb_pkg::SEC_BLUE: begin
        pr = s3.xn; pg = '0;    pb = s3.cn;
      end
      default: begin
        pr = s3.cn; pg = '0;    pb = s3.xn;
      end
    endcase
    s4_next.nr = hsl2rgb_pkg::NUM_W'(pr) + hsl2rgb_pkg::NUM_W'(s3.mn);
    s4_next.ng = hsl2rgb_pkg::NUM_W'(pg) + hsl2rgb_pkg::NUM_W'(s3.mn);
    s4_next.nb = hsl2rgb_pkg::NUM_W'(pb) + hsl2rgb_pkg::NUM_W'(s3.mn);
  end

  // ---------------------------------------------------------------- stage 5
  // divide by 15300 as a reciprocal multiply; exact for every 23-bit numerator
  localparam int MUL_W = hsl2rgb_pkg::NUM_W + hsl2rgb_pkg::RECIP_W;

  logic [MUL_W-1:0] mr, mg, mb;

  always_comb begin
    mr = MUL_W'(s4.nr) * MUL_W'(hsl2rgb_pkg::RECIP);
    mg = MUL_W'(s4.ng) * MUL_W'(hsl2rgb_pkg::RECIP);
    mb = MUL_W'(s4.nb) * MUL_W'(hsl2rgb_pkg::RECIP);
    s5_next.qr = mr[hsl2rgb_pkg::RECIP_SHIFT +: hsl2rgb_pkg::QUOT_W];
    s5_next.qg = mg[hsl2rgb_pkg::RECIP_SHIFT +: hsl2rgb_pkg::QUOT_W];
    s5_next.qb = mb[hsl2rgb_pkg::RECIP_SHIFT +: hsl2rgb_pkg::QUOT_W];
  end

  // ---------------------------------------------------------------- stage 6
  // clamp to 255 as a safeguard; the arithmetic never exceeds it
  always_comb begin
    rgb_next.red   = (s5.qr > 10'(hsl2rgb_pkg::CH_MAX)) ? 8'(hsl2rgb_pkg::CH_MAX) : s5.qr[7:0];
    rgb_next.green = (s5.qg > 10'(hsl2rgb_pkg::CH_MAX)) ? 8'(hsl2rgb_pkg::CH_MAX) : s5.qg[7:0];
    rgb_next.blue  = (s5.qb > 10'(hsl2rgb_pkg::CH_MAX)) ? 8'(hsl2rgb_pkg::CH_MAX) : s5.qb[7:0];
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1 <= s1_next;
    end
    if (en[1]) begin
      s2 <= s2_next;
    end
    if (en[2]) begin
      s3 <= s3_next;
    end
    if (en[3]) begin
      s4 <= s4_next;
    end
    if (en[4]) begin
      s5 <= s5_next;
    end
    if (en[5]) begin
      rgb <= rgb_next;
    end
  end

endmodule

`default_nettype wire

### hdl/hsl2rgb_checker.sv
// hsl2rgb_checker: port-level assertions on hsl_hsv_to_rgb_unit, bound into each instance of it
// depends on hsl2rgb_pkg for the beat types
`default_nettype none

module hsl2rgb_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              pix_valid,
  input wire logic              pix_ready,
  input wire hsl2rgb_pkg::pix_t pix,
  input wire logic              rgb_valid,
  input wire logic              rgb_ready,
  input wire hsl2rgb_pkg::rgb_t rgb
);

  logic quiet;

  // no beat taken in, and the output side is draining
  assign quiet = !(pix_valid && pix_ready) && rgb_ready;

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !rgb_valid)
    else $error("rgb_valid high after reset");

  // the input only stalls when a beat is held at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> (rgb_valid && !rgb_ready))
    else $error("pix_ready low without output backpressure");

  // draining with no new beat taken in leaves nothing behind
  a_drains: assert property (@(posedge clk) disable iff (rst)
    ($past(quiet, 1) && $past(quiet, 2) && $past(quiet, 3) &&
     $past(quiet, 4) && $past(quiet, 5) && $past(quiet, 6)) |-> !rgb_valid)
    else $error("beat appeared with no beat accepted");

  // a held result beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (rgb_valid && !rgb_ready) |=> (rgb_valid && $stable(rgb)))
    else $error("rgb beat changed while stalled");

endmodule

bind hsl_hsv_to_rgb_unit hsl2rgb_checker u_hsl2rgb_checker (.*);

`default_nettype wire
